### hw/rtl/gpmf_pkg.sv
// ----------------------------------------------------------------------------
// gpmf_pkg: shared types and constants of the gated pose median filter
// Widths, register codes, status codes, reset limits and the median helper.
// ----------------------------------------------------------------------------
package gpmf_pkg;

  localparam int WINDOW   = 3;
  localparam int NCH      = 4;
  localparam int SAMPLE_W = 16;
  localparam int LIMIT_W  = 15;
  localparam int SLOT_W   = $clog2(WINDOW);
  localparam int FILL_W   = $clog2(WINDOW + 1);
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int POSE_W   = NCH * SAMPLE_W;
  localparam int USER_W   = 3;

  typedef logic signed [SAMPLE_W-1:0]      sample_t;
  typedef logic [NCH-1:0][SAMPLE_W-1:0]    pose_t;
  typedef logic [LIMIT_W-1:0]              limit_t;
  typedef logic [SLOT_W-1:0]               slot_t;
  typedef logic [FILL_W-1:0]               fill_t;

  typedef enum logic [1:0] {
    ST_RANGE    = 2'd0,
    ST_ZERO     = 2'd1,
    ST_WARMUP   = 2'd2,
    ST_FILTERED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_X_LIMIT   = 2'd0,
    REG_Y_LIMIT   = 2'd1,
    REG_Z_LIMIT   = 2'd2,
    REG_YAW_LIMIT = 2'd3
  } reg_idx_t;

  localparam limit_t X_LIMIT_RST   = 15'd16384;
  localparam limit_t Y_LIMIT_RST   = 15'd6144;
  localparam limit_t Z_LIMIT_RST   = 15'd16384;
  localparam limit_t YAW_LIMIT_RST = 15'd4289;

  // Gate findings of one channel lane.
  typedef struct packed {
    logic over;
    logic zero;
  } gate_t;

  // Window write command shared by all lanes.
  typedef struct packed {
    logic  wr_en;
    slot_t wr_slot;
  } win_wr_t;

  // One finished result.
  typedef struct packed {
    status_t status;
    logic    good;
    pose_t   pose;
  } result_t;

  function automatic sample_t median3(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    sample_t med;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      med = lo;
    end else if (c >= hi) begin
      med = hi;
    end else begin
      med = c;
    end
    return med;
  endfunction

endpackage

### hw/rtl/gpmf_lane.sv
// ----------------------------------------------------------------------------
// gpmf_lane: one channel lane of the pose filter
// Range and zero gate, three-entry ring window and median of the window
// as it stands after the incoming sample is written.
// ----------------------------------------------------------------------------
module gpmf_lane (
  input  logic              clk,
  input  gpmf_pkg::sample_t sample,
  input  gpmf_pkg::limit_t  limit,
  input  gpmf_pkg::win_wr_t win_wr,
  output gpmf_pkg::gate_t   gate,
  output gpmf_pkg::sample_t med
);
  import gpmf_pkg::*;

  sample_t                   win [WINDOW];
  sample_t                   eff [WINDOW];
  logic signed [SAMPLE_W:0]  ext;
  logic        [SAMPLE_W:0]  mag;

  always_comb begin
    ext       = {sample[SAMPLE_W-1], sample};
    mag       = ext[SAMPLE_W] ? (SAMPLE_W+1)'(-ext) : (SAMPLE_W+1)'(ext);
    gate.over = mag > (SAMPLE_W+1)'(limit);
    gate.zero = (sample == '0);
  end

  // The median sees the new sample in place of the slot it overwrites.
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      eff[i] = (win_wr.wr_slot == slot_t'(i)) ? sample : win[i];
    end
    med = median3(eff[0], eff[1], eff[2]);
  end

  always_ff @(posedge clk) begin
    if (win_wr.wr_en) begin
      win[win_wr.wr_slot] <= sample;
    end
  end

endmodule

### hw/rtl/gpmf_merge.sv
// ----------------------------------------------------------------------------
// gpmf_merge: merge stage of the pose filter
// Combines the lane gates, keeps the ring pointer and warm-up count, and
// forms the status and the pose of the result.
// ----------------------------------------------------------------------------
module gpmf_merge (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  gpmf_pkg::gate_t [gpmf_pkg::NCH-1:0] gate,
  input  gpmf_pkg::pose_t               samples,
  input  gpmf_pkg::pose_t               meds,
  output gpmf_pkg::win_wr_t             win_wr,
  output gpmf_pkg::result_t             result
);
  import gpmf_pkg::*;

  slot_t write_slot;
  slot_t write_slot_next;
  fill_t fill_count;
  fill_t fill_count_next;
  logic  any_over;
  logic  any_zero;
  logic  full;
  logic  commit;

  always_comb begin
    any_over = 1'b0;
    any_zero = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      any_over = any_over | gate[i].over;
      any_zero = any_zero | gate[i].zero;
    end
    full   = (fill_count == fill_t'(WINDOW));
    commit = fire && !any_over && !any_zero;

    win_wr.wr_en   = commit;
    win_wr.wr_slot = write_slot;

    // Out of range wins over a zero channel.
    priority if (any_over) begin
      result.status = ST_RANGE;
    end else if (any_zero) begin
      result.status = ST_ZERO;
    end else if (!full) begin
      result.status = ST_WARMUP;
    end else begin
      result.status = ST_FILTERED;
    end
    result.good = (result.status == ST_FILTERED);
    result.pose = result.good ? meds : samples;

    write_slot_next = (write_slot == slot_t'(WINDOW - 1)) ? '0 : slot_t'(write_slot + 1'b1);
    fill_count_next = full ? fill_count : fill_t'(fill_count + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (commit) begin
      write_slot <= write_slot_next;
      fill_count <= fill_count_next;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= slot_t'(WINDOW - 1))
    else $error("ring pointer outside the window");

  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (commit && !full) |=> (fill_count == $past(fill_count) + 1'b1))
    else $error("warm-up count did not advance on an accepted sample");

  a_hold_on_reject: assert property (@(posedge clk) disable iff (rst)
    !commit |=> ($stable(write_slot) && $stable(fill_count)))
    else $error("window state moved without an accepted sample");

endmodule

### hw/rtl/gated_pose_median_filter_top.sv
// ----------------------------------------------------------------------------
// gated_pose_median_filter_top: gated median-of-3 pose filter
// Stream in, stream out, APB limit registers; four channel lanes and a merge.
// ----------------------------------------------------------------------------
// The filter takes one pose beat (x, y, z, heading, signed Q3.12) per clock
// cycle while s_tready is high and returns exactly one result beat for each,
// in order. A sample whose channel magnitude exceeds its limit register is
// reported with status 0, one with any channel exactly zero with status 1;
// both pass the input through and leave the window untouched. The first three
// accepted samples report status 2 (warming up) and the fourth and later
// report status 3 with good set and the per-channel median of the last three
// accepted samples. The rate is one beat per cycle, set by the single
// register stage after the lanes; an extra skid register behind it lets the
// input keep taking a beat while a result waits for the downstream side, and
// s_tready drops only when both are full. Limits are written over APB at
// byte addresses 0, 4, 8 and 12 (x, y, z, yaw; 15 bits each) and should only
// be changed while the stream is idle.
// ----------------------------------------------------------------------------
module gated_pose_median_filter_top (
  input  logic                          clk,
  input  logic                          rst,
  // stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, low to high: pos_x[15:0], pos_y[31:16], pos_z[47:32], heading[63:48]
  input  logic [gpmf_pkg::POSE_W-1:0]   s_tdata,
  // stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, low to high: med_x[15:0], med_y[31:16], med_z[47:32],
  // med_heading[63:48]
  output logic [gpmf_pkg::POSE_W-1:0]   m_tdata,
  // m_tuser, low to high: status[1:0], good[2]
  output logic [gpmf_pkg::USER_W-1:0]   m_tuser,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gpmf_pkg::ADDR_W-1:0]   paddr,
  input  logic [gpmf_pkg::DATA_W-1:0]   pwdata,
  output logic [gpmf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import gpmf_pkg::*;

  limit_t            limits [NCH];
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  logic              s_fire;
  logic              m_fire;
  pose_t             samples;
  pose_t             meds;
  gate_t [NCH-1:0]   gate;
  win_wr_t           win_wr;
  result_t           result;
  result_t           out;
  logic              out_valid;
  result_t           skid;
  logic              sk_valid;

  // Configuration registers. The register index is the word address.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = DATA_W'(limits[reg_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      limits[REG_X_LIMIT]   <= X_LIMIT_RST;
      limits[REG_Y_LIMIT]   <= Y_LIMIT_RST;
      limits[REG_Z_LIMIT]   <= Z_LIMIT_RST;
      limits[REG_YAW_LIMIT] <= YAW_LIMIT_RST;
    end else if (cfg_wr) begin
      limits[reg_idx] <= pwdata[LIMIT_W-1:0];
    end
  end

  // Handshakes. The input is held off only when the skid register is full.
  assign s_tready = !sk_valid;
  assign s_fire   = s_tvalid && s_tready;
  assign m_fire   = out_valid && m_tready;
  assign samples  = pose_t'(s_tdata);

  // One lane per pose channel.
  for (genvar g = 0; g < NCH; g++) begin : g_lane
    gpmf_lane u_lane (
      .clk    (clk),
      .sample (sample_t'(samples[g])),
      .limit  (limits[g]),
      .win_wr (win_wr),
      .gate   (gate[g]),
      .med    (meds[g])
    );
  end

  gpmf_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .fire    (s_fire),
    .gate    (gate),
    .samples (samples),
    .meds    (meds),
    .win_wr  (win_wr),
    .result  (result)
  );

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (m_fire) begin
        sk_valid <= 1'b0;
      end
    end else if (s_fire) begin
      if (out_valid && !m_tready) begin
        sk_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (m_fire) begin
        out <= skid;
      end
    end else if (s_fire) begin
      if (out_valid && !m_tready) begin
        skid <= result;
      end else begin
        out <= result;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out.pose;
  assign m_tuser  = {out.good, out.status};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> out_valid)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (sk_valid && m_tready) |=> (out_valid && !sk_valid))
    else $error("skid beat not moved to the output register");

  a_good_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out.good == (out.status == ST_FILTERED)))
    else $error("good flag disagrees with status");

endmodule
